FILE: rtl/msfe_pkg.sv
// msfe_pkg: shared constants, types and register codes for the multi-sensor FIR estimator.
// No dependencies; imported by multi_sensor_fir_estimator, estimate_check_pkg and tb_top.
package msfe_pkg;

   localparam int LANES        = 4;   // sample lanes per beat, fixed by the register layout
   localparam int SENSORS      = 4;   // lanes actually fed; higher lanes read as zero
   localparam int ORDER        = 4;   // history depth
   localparam int OFFSET_SLOTS = 4;   // offset table entries
   localparam int COEF_REGS    = 4;   // coefficient registers, one per lag

   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int TAPS       = ORDER * LANES;
   localparam int ACC_W      = PROD_W + $clog2(TAPS) + 1;
   localparam int FRAC_SHIFT = 14;
   localparam int SUM_W      = ACC_W - FRAC_SHIFT;
   localparam int RES_W      = SUM_W + 1;
   localparam int SLOT_W     = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int ORD_W      = 3;
   localparam int ORD_EFF_W  = $clog2(ORDER + 1) + 1;
   localparam int ENTRY_CAP  = (OFFSET_SLOTS < LANES) ? OFFSET_SLOTS : LANES;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = LANES * SAMPLE_W;
   localparam int DATA_W     = LANES * SAMPLE_W;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF0  = 4'd0,
      CSR_COEFF1  = 4'd1,
      CSR_COEFF2  = 4'd2,
      CSR_COEFF3  = 4'd3,
      CSR_LIMITS  = 4'd4,
      CSR_AMOUNTS = 4'd5,
      CSR_ORDER   = 4'd6,
      CSR_ENTRIES = 4'd7
   } csr_index_type;

   function automatic sample_type lane16(input logic [CSR_DATA_W-1:0] word, input int lane);
      sample_type v;
      v = sample_type'(word[lane*SAMPLE_W +: SAMPLE_W]);
      return v;
   endfunction

endpackage

FILE: rtl/multi_sensor_fir_estimator.sv
// multi_sensor_fir_estimator: four-lane FIR over a sample ring, rounding, piecewise
// offset and 16-bit saturation. Depends on msfe_pkg.
//
//  channel  direction  handshake             payload
//  req_     in         req_tvalid/tready     tdata: sensor_a..sensor_d (16b each)
//  rsp_     out        rsp_tvalid/tready     tdata: estimate; tuser: saturated
//  csr_     in         csr_valid/csr_ready   csr_index, csr_data
//
// Five-stage pipeline: lag select and ring write, products, per-lag sums, total and
// rounding, offset and saturation into the output register. One beat per cycle unless
// rsp_tready stalls; a beat passes the lag, product, sum and total registers before
// rsp_tvalid rises with it in the output register. The 16 parallel 16x16 multipliers
// set the stage cost. A stage stalls only when the one after it is full and not draining.
// Reset (synchronous) clears the valid flags, configuration (order to 1), ring pointer and
// priming flag; the ring and payload registers hold no reset value, and the first beat fills the ring.
module multi_sensor_fir_estimator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [msfe_pkg::DATA_W-1:0]         req_tdata,   // sensor_a, sensor_b, sensor_c, sensor_d
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [msfe_pkg::SAMPLE_W-1:0]       rsp_tdata,   // estimate
   output logic                                rsp_tuser,   // saturated
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [msfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msfe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import msfe_pkg::*;

   localparam int NSTAGE = 5;

   // configuration
   logic [CSR_DATA_W-1:0] coeff_ff [COEF_REGS];
   logic [CSR_DATA_W-1:0] limits_ff;
   logic [CSR_DATA_W-1:0] amounts_ff;
   logic [ORD_W-1:0]      order_ff;
   logic [ORD_W-1:0]      entries_ff;

   // ring state
   sample_type        history_ff [ORDER][LANES];
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic              primed_ff, primed_in;

   // pipeline
   logic [NSTAGE-1:0] vld_ff, vld_in;
   logic [NSTAGE-1:0] load;
   sample_type        lag_ff  [ORDER][LANES];
   sample_type        lag_in  [ORDER][LANES];
   prod_type          prod_ff [ORDER][LANES];
   prod_type          prod_in [ORDER][LANES];
   acc_type           lsum_ff [ORDER];
   acc_type           lsum_in [ORDER];
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0]        est_ff, est_in;
   logic                       sat_ff, sat_in;

   logic                  accept;
   sample_type            sample [LANES];
   logic [ORD_EFF_W-1:0]  ord_eff;
   logic [SLOT_W-1:0]     slot;
   logic [4:0]            lvl_wide [ORDER];

   assign csr_ready = 1'b1;

   // stall chain: a stage loads when it is empty or its content moves on
   always_comb begin
      load[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      vld_in[0] = req_tvalid;
      for (int k = 1; k < NSTAGE; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_tready = load[0];
   assign accept     = req_tvalid && req_tready;

   // stage 0: ring write and lag selection
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         sample[j] = (j < SENSORS) ? lane16(req_tdata, j) : '0;
      end

      if (order_ff == '0) begin
         ord_eff = ORD_EFF_W'(1);
      end else if (ORD_EFF_W'(order_ff) > ORD_EFF_W'(ORDER)) begin
         ord_eff = ORD_EFF_W'(ORDER);
      end else begin
         ord_eff = ORD_EFF_W'(order_ff);
      end

      slot = (ORD_EFF_W'(write_slot_ff) < ord_eff) ? write_slot_ff : '0;

      for (int i = 0; i < ORDER; i++) begin
         // lags count back from the write slot, wrapping at order - 1
         if (5'(slot) >= 5'(i)) begin
            lvl_wide[i] = 5'(slot) - 5'(i);
         end else begin
            lvl_wide[i] = 5'(slot) + 5'(ord_eff) - 5'(i);
         end
         for (int j = 0; j < LANES; j++) begin
            if (ORD_EFF_W'(i) >= ord_eff) begin
               lag_in[i][j] = '0;
            end else if (i == 0 || !primed_ff) begin
               lag_in[i][j] = sample[j];
            end else begin
               lag_in[i][j] = history_ff[lvl_wide[i][SLOT_W-1:0]][j];
            end
         end
      end

      if (ORD_EFF_W'(slot) + ORD_EFF_W'(1) < ord_eff) begin
         write_slot_in = slot + SLOT_W'(1);
      end else begin
         write_slot_in = '0;
      end
      primed_in = 1'b1;
   end

   // stage 1: products; lags past the coefficient registers weigh zero
   always_comb begin
      for (int i = 0; i < ORDER; i++) begin
         for (int j = 0; j < LANES; j++) begin
            if (i < COEF_REGS) begin
               prod_in[i][j] = PROD_W'(lane16(coeff_ff[i], j)) * PROD_W'(lag_ff[i][j]);
            end else begin
               prod_in[i][j] = '0;
            end
         end
      end
   end

   // stage 2: per-lag sums
   always_comb begin
      for (int i = 0; i < ORDER; i++) begin
         lsum_in[i] = '0;
         for (int j = 0; j < LANES; j++) begin
            lsum_in[i] = lsum_in[i] + ACC_W'(prod_ff[i][j]);
         end
      end
   end

   // stage 3: total, then round half up, dropping the 14 fraction bits of the Q2.14 coefficients
   always_comb begin
      acc_type total;
      total = acc_type'(1 <<< (FRAC_SHIFT - 1));
      for (int i = 0; i < ORDER; i++) begin
         total = total + lsum_ff[i];
      end
      sum_in = SUM_W'(total >>> FRAC_SHIFT);
   end

   // stage 4: offset of the highest used entry whose threshold lies below the sum, then saturation
   always_comb begin
      logic [ORD_EFF_W-1:0]       ent;
      logic signed [SUM_W-1:0]    off;
      logic signed [SUM_W-1:0]    lim;
      logic signed [RES_W-1:0]    res;
      if (ORD_EFF_W'(entries_ff) > ORD_EFF_W'(ENTRY_CAP)) begin
         ent = ORD_EFF_W'(ENTRY_CAP);
      end else begin
         ent = ORD_EFF_W'(entries_ff);
      end
      off = '0;
      for (int i = 0; i < ENTRY_CAP; i++) begin
         lim = SUM_W'(lane16(limits_ff, i));
         if (ORD_EFF_W'(i) < ent && lim < sum_ff) begin
            off = SUM_W'(lane16(amounts_ff, i));
         end
      end
      res = RES_W'(sum_ff) + RES_W'(off);
      if (res > RES_W'(sample_type'(16'sh7FFF))) begin
         est_in = 16'h7FFF;
         sat_in = 1'b1;
      end else if (res < RES_W'(sample_type'(16'sh8000))) begin
         est_in = 16'h8000;
         sat_in = 1'b1;
      end else begin
         est_in = res[SAMPLE_W-1:0];
         sat_in = 1'b0;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         write_slot_ff <= '0;
         primed_ff     <= 1'b0;
         for (int r = 0; r < COEF_REGS; r++) begin
            coeff_ff[r] <= '0;
         end
         limits_ff  <= '0;
         amounts_ff <= '0;
         order_ff   <= ORD_W'(1);
         entries_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (load[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
         if (accept) begin
            write_slot_ff <= write_slot_in;
            primed_ff     <= primed_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEFF0:  coeff_ff[0] <= csr_data;
               CSR_COEFF1:  coeff_ff[1] <= csr_data;
               CSR_COEFF2:  coeff_ff[2] <= csr_data;
               CSR_COEFF3:  coeff_ff[3] <= csr_data;
               CSR_LIMITS:  limits_ff   <= csr_data;
               CSR_AMOUNTS: amounts_ff  <= csr_data;
               CSR_ORDER:   order_ff    <= csr_data[ORD_W-1:0];
               CSR_ENTRIES: entries_ff  <= csr_data[ORD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ring and payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int s = 0; s < ORDER; s++) begin
            if (!primed_ff || SLOT_W'(s) == slot) begin
               for (int j = 0; j < LANES; j++) begin
                  history_ff[s][j] <= sample[j];
               end
            end
         end
         lag_ff <= lag_in;
      end
      if (load[1] && vld_ff[0]) begin
         prod_ff <= prod_in;
      end
      if (load[2] && vld_ff[1]) begin
         lsum_ff <= lsum_in;
      end
      if (load[3] && vld_ff[2]) begin
         sum_ff <= sum_in;
      end
      if (load[4] && vld_ff[3]) begin
         est_ff <= est_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tdata  = est_ff;
   assign rsp_tuser  = sat_ff;

   // checks
   a_primed_sticky: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("priming flag dropped");

   a_first_beat_primes: assert property (@(posedge clock) disable iff (reset)
      (accept && !primed_ff) |=> primed_ff)
      else $error("first beat did not prime the ring");

   a_slot_in_order: assert property (@(posedge clock) disable iff (reset)
      accept |=> (ORD_EFF_W'(write_slot_ff) < $past(ord_eff)))
      else $error("ring pointer beyond active order");

   a_sat_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000))
      else $error("saturation flag without clipped value");

endmodule

FILE: dv/estimate_check_pkg.sv
// estimate_check_pkg: scoreboard for the multi-sensor FIR estimator bench. It predicts each
// response beat from the register image and a private sample ring. Depends on msfe_pkg.
package estimate_check_pkg;
   import msfe_pkg::*;

   typedef struct packed {
      logic [SAMPLE_W-1:0] estimate;
      logic                clipped;
   } estimate_type;

   class estimate_scoreboard;
      logic [CSR_DATA_W-1:0] coeff_words [COEF_REGS];
      logic [CSR_DATA_W-1:0] limit_word;
      logic [CSR_DATA_W-1:0] amount_word;
      logic [ORD_W-1:0]      order_reg;
      logic [ORD_W-1:0]      entries_reg;
      sample_type            sample_ring [ORDER][LANES];
      int                    write_slot;
      bit                    primed;
      estimate_type          estimates_due [$];
      int                    errors;

      function new();
         for (int i = 0; i < COEF_REGS; i++) coeff_words[i] = '0;
         limit_word  = '0;
         amount_word = '0;
         order_reg   = ORD_W'(1);
         entries_reg = '0;
         write_slot  = 0;
         primed      = 1'b0;
         errors      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_COEFF0, CSR_COEFF1, CSR_COEFF2, CSR_COEFF3: coeff_words[index[1:0]] = value;
            CSR_LIMITS:  limit_word  = value;
            CSR_AMOUNTS: amount_word = value;
            CSR_ORDER:   order_reg   = value[ORD_W-1:0];
            CSR_ENTRIES: entries_reg = value[ORD_W-1:0];
            default: ;  // unmapped, dropped
         endcase
      endfunction

      function int pending();
         return estimates_due.size();
      endfunction

      // One request beat in, one predicted estimate queued.
      function void note_beat(logic [DATA_W-1:0] beat);
         sample_type   lanes [LANES];
         sample_type   coeff;
         int           taps, slot, lag_slot, used;
         longint       acc, sum, offset, total;
         longint       half   = longint'(1) << (FRAC_SHIFT - 1);
         longint       top    = (longint'(1) << (SAMPLE_W - 1)) - 1;
         longint       bottom = -(longint'(1) << (SAMPLE_W - 1));
         estimate_type want;

         acc    = 0;
         offset = 0;
         for (int j = 0; j < LANES; j++)
            lanes[j] = (j < SENSORS) ? sample_type'(beat[j*SAMPLE_W +: SAMPLE_W]) : '0;

         taps = (order_reg == 0) ? 1 : (order_reg > ORDER) ? ORDER : int'(order_reg);

         if (!primed) begin
            for (int i = 0; i < ORDER; i++) sample_ring[i] = lanes;
            primed = 1'b1;
         end

         // pointer past a lowered order restarts at slot 0
         slot = (write_slot < taps) ? write_slot : 0;
         sample_ring[slot] = lanes;
         lag_slot = slot;
         for (int lag = 0; lag < taps; lag++) begin
            for (int j = 0; j < SENSORS && j < LANES; j++) begin
               coeff = (lag < COEF_REGS) ?
                       sample_type'(coeff_words[lag][j*SAMPLE_W +: SAMPLE_W]) : '0;
               acc += longint'(coeff) * longint'(sample_ring[lag_slot][j]);
            end
            lag_slot = (lag_slot == 0) ? taps - 1 : lag_slot - 1;
         end
         write_slot = (slot + 1 < taps) ? slot + 1 : 0;

         sum = (acc + half) >>> FRAC_SHIFT;  // floor after adding half: ties go up

         used = (entries_reg > ENTRY_CAP) ? ENTRY_CAP : int'(entries_reg);
         for (int k = used - 1; k >= 0; k--) begin
            if (longint'(sample_type'(limit_word[k*SAMPLE_W +: SAMPLE_W])) < sum) begin
               offset = sample_type'(amount_word[k*SAMPLE_W +: SAMPLE_W]);
               break;
            end
         end

         total = sum + offset;
         want.clipped = (total > top) || (total < bottom);
         if (total > top)
            total = top;
         else if (total < bottom)
            total = bottom;
         want.estimate = total[SAMPLE_W-1:0];
         estimates_due.push_back(want);
      endfunction

      task check_estimate(logic [SAMPLE_W-1:0] estimate, logic clipped);
         estimate_type want;
         if (estimates_due.size() == 0) begin
            report_mismatch($sformatf("estimate %h with nothing outstanding", estimate));
         end else begin
            want = estimates_due.pop_front();
            if (estimate !== want.estimate)
               report_mismatch($sformatf("estimate %h, predicted %h", estimate, want.estimate));
            if (clipped !== want.clipped)
               report_mismatch($sformatf("saturated %b, predicted %b", clipped, want.clipped));
         end
      endtask

      task report_mismatch(string what);
         if (errors < 100)
            $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask
   endclass

endpackage

FILE: dv/tb_top.sv
// tb_top: drives multi_sensor_fir_estimator through directed and random register settings
// and sensor beats, with random stalls on both channels. Depends on msfe_pkg, estimate_check_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msfe_pkg::*;
   import estimate_check_pkg::*;

   localparam int REG_COUNT     = 8;       // indexes from here up are unmapped
   localparam int PHASES        = 11;
   localparam int PHASE_BEATS   = 150;
   localparam int SETTLE_CYCLES = 8;       // idle margin after the last response
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 500000;

   typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EDGE, STYLE_MAX, STYLE_MIN} lane_style_type;

   typedef struct {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
   } csr_write_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   estimate_scoreboard scoreboard;
   csr_write_type      csr_backlog [$];
   bit                 idle_on      = 1'b1;
   bit                 hold_request = 1'b0;
   int                 cycle_count  = 0;

   multi_sensor_fir_estimator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: random stall bursts, or one long hold on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Register writes, request beats and response beats in handshake order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            scoreboard.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            scoreboard.note_beat(req_tdata);
         if (rsp_tvalid && rsp_tready)
            scoreboard.check_estimate(rsp_tdata, rsp_tuser);
      end
   end

   function automatic logic [DATA_W-1:0] random_lanes(lane_style_type style);
      logic [DATA_W-1:0]   word;
      logic [SAMPLE_W-1:0] lane;
      for (int j = 0; j < LANES; j++) begin
         case (style)
            STYLE_SMALL: begin
               lane = SAMPLE_W'($urandom_range(0, 16'h0FFF));
               if ($urandom_range(0, 1) == 1) lane = -lane;
            end
            STYLE_EDGE: begin
               case ($urandom_range(0, 3))
                  0:       lane = 16'h7FFF;
                  1:       lane = 16'h8000;
                  2:       lane = 16'h0000;
                  default: lane = 16'hFFFF;
               endcase
            end
            STYLE_MAX: lane = 16'h7FFF;
            STYLE_MIN: lane = 16'h8000;
            default:   lane = SAMPLE_W'($urandom);
         endcase
         word[j*SAMPLE_W +: SAMPLE_W] = lane;
      end
      return word;
   endfunction

   task automatic queue_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_backlog.push_back('{index, value});
   endtask

   task automatic flush_regs();
      csr_write_type w;
      while (csr_backlog.size() != 0) begin
         w = csr_backlog.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // valid stays up after a beat; the caller either offers the next one or settles
   task automatic send_beat(logic [DATA_W-1:0] beat);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                ph;
      lane_style_type    cstyle;
      lane_style_type    beat_style;
      logic [ORD_W-1:0]  ord;
      logic [ORD_W-1:0]  ents;

      scoreboard = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full order, mixed coefficients, four-entry offset table
      queue_reg(CSR_COEFF0,  64'h1000_2000_3000_4000);
      queue_reg(CSR_COEFF1,  64'hE000_2000_C000_2000);
      queue_reg(CSR_COEFF2,  64'h0800_F000_1000_0400);
      queue_reg(CSR_COEFF3,  64'h8000_7FFF_0001_FFFF);
      queue_reg(CSR_LIMITS,  64'h7000_1000_0000_F000);
      queue_reg(CSR_AMOUNTS, 64'h0010_8000_7FFF_0100);
      queue_reg(CSR_IDX_W'(REG_COUNT), '1);
      queue_reg(CSR_ORDER,   64'd4);
      queue_reg(CSR_ENTRIES, 64'd4);
      flush_regs();
      send_beat(64'h0100_0100_0100_0100);  // first beat fills every lag
      send_beat(64'h7FFF_7FFF_7FFF_7FFF);
      send_beat(64'h7FFF_7FFF_7FFF_7FFF);
      send_beat(64'h8000_8000_8000_8000);
      send_beat(64'h8000_8000_8000_8000);
      send_beat(64'h0000_0000_0000_0000);
      send_beat(64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(64'h7FFF_8000_7FFF_8000);
      send_beat(64'h8000_7FFF_8000_7FFF);
      send_beat(random_lanes(STYLE_SMALL));
      send_beat(random_lanes(STYLE_SMALL));
      settle();

      // ring pointer now at 3; order zero means one lag and forces the stale-slot restart.
      // Table length clamps, thresholds at max never match, tiny coefficient shows rounding.
      queue_reg(CSR_ORDER,   64'd0);
      queue_reg(CSR_ENTRIES, 64'd6);
      queue_reg(CSR_LIMITS,  64'h7FFF_7FFF_7FFF_7FFF);
      queue_reg(CSR_COEFF0,  64'h0000_0000_0000_0001);
      queue_reg('1,          64'h0123_4567_89AB_CDEF);
      flush_regs();
      send_beat(64'h0000_0000_0000_2000);  // +0.5 LSB rounds up
      send_beat(64'h0000_0000_0000_E000);  // -0.5 LSB rounds up to zero
      send_beat(64'h0000_0000_0000_6000);
      send_beat(64'h0000_0000_0000_A000);
      settle();

      // order above the history depth acts as full depth
      queue_reg(CSR_ORDER, 64'd7);
      flush_regs();
      repeat (4) send_beat(random_lanes(STYLE_FULL));

      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         idle_on = (ph < PHASES - 2);
         cstyle  = (ph == 1) ? STYLE_MAX :
                   (ph == 2) ? STYLE_MIN : lane_style_type'($urandom_range(0, 2));
         for (int r = 0; r < COEF_REGS; r++)
            queue_reg(CSR_IDX_W'(r), random_lanes(cstyle));
         queue_reg(CSR_LIMITS,  random_lanes(lane_style_type'($urandom_range(0, 2))));
         queue_reg(CSR_AMOUNTS, random_lanes(lane_style_type'($urandom_range(0, 2))));
         ord  = ORD_W'((ph == 0) ? 1 : (ph == 1) ? ORDER : (ph == 2) ? 7 :
                       int'($urandom_range(0, 7)));
         ents = ORD_W'((ph == 0) ? 0 : (ph == 1) ? ENTRY_CAP : (ph == 2) ? 7 :
                       int'($urandom_range(0, 7)));
         // junk above the 3-bit fields must be dropped
         queue_reg(CSR_ORDER,   {$urandom, 29'($urandom), ord});
         queue_reg(CSR_ENTRIES, {$urandom, 29'($urandom), ents});
         if ($urandom_range(0, 3) == 0)
            queue_reg(CSR_IDX_W'($urandom_range(REG_COUNT, 15)), random_lanes(STYLE_FULL));
         flush_regs();

         if (ph == 3 || ph == 7)
            hold_request = 1'b1;  // pipeline fills, request side backs up

         repeat (PHASE_BEATS) begin
            beat_style = ($urandom_range(0, 19) < 17) ? STYLE_FULL :
                         ($urandom_range(0, 1) == 1) ? STYLE_SMALL : STYLE_EDGE;
            send_beat(random_lanes(beat_style));
         end
      end
      settle();

      if (scoreboard.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
